FILE: rtl/w2vft_pkg.sv
// Shared types, constants and lookup functions for the world-to-vehicle
// frame transform. No dependencies.
package w2vft_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
	localparam int GUARD_BITS    = 8;
	// guard bits, one for the half-turn negation, two for CORDIC growth
	localparam int ROT_WIDTH     = COORD_WIDTH + GUARD_BITS + 3;
	localparam int ANG_WIDTH     = 33;
	localparam int HEADING_WIDTH = 16;
	localparam int ANGLE_EXT     = HEADING_WIDTH + 1;
	localparam int QUARTER_TURN  = 2 ** (HEADING_WIDTH - 2);
	localparam int HALF_TURN     = 2 ** (HEADING_WIDTH - 1);
	localparam int GAIN_WIDTH    = 30;
	localparam int GAIN_FRAC     = 30 + GUARD_BITS;
	localparam int MAX_STEPS     = 30;
	localparam int DATA_WIDTH    = 32;
	localparam int ADDR_WIDTH    = 4;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_POSE_X  = 2'd0,
		REG_POSE_Y  = 2'd1,
		REG_HEADING = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] world_x;
		logic signed [COORD_WIDTH-1:0] world_y;
	} wp_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] car_x;
		logic signed [COORD_WIDTH-1:0] car_y;
		logic                          clipped;
	} res_t;

	// vector and residual angle inside the rotation pipeline
	typedef struct packed {
		logic signed [ROT_WIDTH-1:0] x;
		logic signed [ROT_WIDTH-1:0] y;
		logic signed [ANG_WIDTH-1:0] z;
		logic                        clip;
	} rot_t;

	// atan(2^-i) in units of 2^32 per turn
	function automatic logic [ANG_WIDTH-1:0] atan_of(input int unsigned idx);
		logic [ANG_WIDTH-1:0] a;
		case (idx)
			0:  a = 33'd536870912;
			1:  a = 33'd316933406;
			2:  a = 33'd167458907;
			3:  a = 33'd85004756;
			4:  a = 33'd42667331;
			5:  a = 33'd21354465;
			6:  a = 33'd10680862;
			7:  a = 33'd5345367;
			8:  a = 33'd2670163;
			9:  a = 33'd1335087;
			10: a = 33'd667544;
			11: a = 33'd333772;
			12: a = 33'd166886;
			13: a = 33'd83443;
			14: a = 33'd41722;
			15: a = 33'd20861;
			16: a = 33'd10430;
			17: a = 33'd5215;
			18: a = 33'd2608;
			19: a = 33'd1304;
			20: a = 33'd652;
			21: a = 33'd326;
			22: a = 33'd163;
			23: a = 33'd81;
			24: a = 33'd41;
			25: a = 33'd20;
			26: a = 33'd10;
			27: a = 33'd5;
			28: a = 33'd3;
			29: a = 33'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// round(2^30 / K_n); step counts below 8 use n = 8, above 14 the value is flat
	function automatic logic [GAIN_WIDTH-1:0] gain_of(input int steps);
		logic [GAIN_WIDTH-1:0] g;
		case (steps)
			9:  g = 30'd652034532;
			10: g = 30'd652033289;
			11: g = 30'd652032978;
			12: g = 30'd652032900;
			13: g = 30'd652032881;
			14: g = 30'd652032876;
			default: g = (steps <= 8) ? 30'd652039507 : 30'd652032874;
		endcase
		return g;
	endfunction

endpackage

FILE: rtl/w2vft_cordic.sv
// Unrolled CORDIC rotation: one registered micro-rotation per stage.
// Depends on w2vft_pkg.
module w2vft_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  w2vft_pkg::rot_t in_rot,
	output logic            out_valid,
	input  logic            out_ready,
	output w2vft_pkg::rot_t out_rot
);
	import w2vft_pkg::*;

	localparam int RUN_STEPS = (CORDIC_STEPS < 1) ? 1 :
		((CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS);
	localparam logic signed [ANG_WIDTH-1:0] Z_BOUND =
		ANG_WIDTH'(2 * atan_of(RUN_STEPS - 1) + 2 * RUN_STEPS);

	rot_t                 rot_s [RUN_STEPS];
	rot_t                 src_rot [RUN_STEPS];
	logic [RUN_STEPS-1:0] vld_s;
	logic [RUN_STEPS-1:0] src_vld;
	logic [RUN_STEPS-1:0] en;

	for (genvar k = 0; k < RUN_STEPS; k++) begin : g_stage
		rot_t                        nxt;
		logic signed [ROT_WIDTH-1:0] xi, yi, xs, ys;
		logic [ANG_WIDTH-1:0]        ang;

		if (k == 0) begin : g_head
			assign src_rot[k] = in_rot;
			assign src_vld[k] = in_valid;
		end else begin : g_body
			assign src_rot[k] = rot_s[k-1];
			assign src_vld[k] = vld_s[k-1];
		end

		// stage moves when empty or when the next one moves
		if (k == RUN_STEPS - 1) begin : g_tail_en
			assign en[k] = !vld_s[k] || out_ready;
		end else begin : g_mid_en
			assign en[k] = !vld_s[k] || en[k+1];
		end

		assign ang = atan_of(k);
		assign xi  = src_rot[k].x;
		assign yi  = src_rot[k].y;
		assign xs  = xi >>> k;
		assign ys  = yi >>> k;

		always_comb begin
			nxt = src_rot[k];
			if (!src_rot[k].z[ANG_WIDTH-1]) begin
				nxt.x = xi - ys;
				nxt.y = yi + xs;
				nxt.z = src_rot[k].z - ang;
			end else begin
				nxt.x = xi + ys;
				nxt.y = yi - xs;
				nxt.z = src_rot[k].z + ang;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= src_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && src_vld[k]) begin
				rot_s[k] <= nxt;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[RUN_STEPS-1];
	assign out_rot   = rot_s[RUN_STEPS-1];

	// the residual angle must have converged by the last stage
	a_converged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_rot.z <= Z_BOUND && out_rot.z >= -Z_BOUND))
		else $error("cordic residual angle did not converge");

endmodule

FILE: rtl/w2vft_gain.sv
// Gain correction: scales both rotated components by 1/K, rounds half away
// from zero and saturates to the coordinate range. Depends on w2vft_pkg.
module w2vft_gain #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  w2vft_pkg::rot_t in_rot,
	output logic            out_valid,
	input  logic            out_ready,
	output w2vft_pkg::res_t out_res
);
	import w2vft_pkg::*;

	localparam int LO_W      = ROT_WIDTH / 2;
	localparam int HI_W      = ROT_WIDTH - LO_W;
	localparam int LO_PROD_W = LO_W + GAIN_WIDTH;
	localparam int HI_PROD_W = HI_W + GAIN_WIDTH;
	localparam int SUM_W     = ROT_WIDTH + GAIN_WIDTH + 1;
	localparam int Q_W       = SUM_W - GAIN_FRAC;

	localparam logic [GAIN_WIDTH-1:0] GAIN    = gain_of(CORDIC_STEPS);
	localparam logic [SUM_W-1:0]      ROUND   = SUM_W'(1) << (GAIN_FRAC - 1);
	localparam logic [Q_W-1:0]        POS_LIM = Q_W'(COORD_MAX);
	localparam logic [Q_W-1:0]        NEG_LIM = POS_LIM + Q_W'(1);

	// stage 1: sign and magnitude
	logic                 vld_s1, neg_x_s1, neg_y_s1, clip_s1;
	logic [ROT_WIDTH-1:0] mag_x_s1, mag_y_s1;
	// stage 2: partial products
	logic                 vld_s2, neg_x_s2, neg_y_s2, clip_s2;
	logic [LO_PROD_W-1:0] plo_x_s2, plo_y_s2;
	logic [HI_PROD_W-1:0] phi_x_s2, phi_y_s2;
	// stage 3: rounded quotient
	logic                 vld_s3, neg_x_s3, neg_y_s3, clip_s3;
	logic [Q_W-1:0]       q_x_s3, q_y_s3;
	// stage 4: saturated result
	logic                 vld_s4;
	res_t                 res_s4;

	logic                 en_s1, en_s2, en_s3, en_s4;
	logic [SUM_W-1:0]     sum_x, sum_y;
	logic                 ovf_x, ovf_y;
	logic [COORD_WIDTH-1:0] car_x, car_y;

	assign en_s4 = !vld_s4 || out_ready;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	always_comb begin
		sum_x = SUM_W'({phi_x_s2, {LO_W{1'b0}}}) + SUM_W'(plo_x_s2) + ROUND;
		sum_y = SUM_W'({phi_y_s2, {LO_W{1'b0}}}) + SUM_W'(plo_y_s2) + ROUND;
	end

	always_comb begin
		ovf_x = neg_x_s3 ? (q_x_s3 > NEG_LIM) : (q_x_s3 > POS_LIM);
		ovf_y = neg_y_s3 ? (q_y_s3 > NEG_LIM) : (q_y_s3 > POS_LIM);
		if (ovf_x) begin
			car_x = neg_x_s3 ? COORD_MIN : COORD_MAX;
		end else begin
			car_x = neg_x_s3 ? -q_x_s3[COORD_WIDTH-1:0] : q_x_s3[COORD_WIDTH-1:0];
		end
		if (ovf_y) begin
			car_y = neg_y_s3 ? COORD_MIN : COORD_MAX;
		end else begin
			car_y = neg_y_s3 ? -q_y_s3[COORD_WIDTH-1:0] : q_y_s3[COORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			neg_x_s1 <= in_rot.x[ROT_WIDTH-1];
			neg_y_s1 <= in_rot.y[ROT_WIDTH-1];
			mag_x_s1 <= in_rot.x[ROT_WIDTH-1] ? -in_rot.x : in_rot.x;
			mag_y_s1 <= in_rot.y[ROT_WIDTH-1] ? -in_rot.y : in_rot.y;
			clip_s1  <= in_rot.clip;
		end
		if (en_s2 && vld_s1) begin
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			clip_s2  <= clip_s1;
			plo_x_s2 <= LO_PROD_W'(mag_x_s1[LO_W-1:0]) * LO_PROD_W'(GAIN);
			plo_y_s2 <= LO_PROD_W'(mag_y_s1[LO_W-1:0]) * LO_PROD_W'(GAIN);
			phi_x_s2 <= HI_PROD_W'(mag_x_s1[ROT_WIDTH-1:LO_W]) * HI_PROD_W'(GAIN);
			phi_y_s2 <= HI_PROD_W'(mag_y_s1[ROT_WIDTH-1:LO_W]) * HI_PROD_W'(GAIN);
		end
		if (en_s3 && vld_s2) begin
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
			clip_s3  <= clip_s2;
			q_x_s3   <= sum_x[SUM_W-1:GAIN_FRAC];
			q_y_s3   <= sum_y[SUM_W-1:GAIN_FRAC];
		end
		if (en_s4 && vld_s3) begin
			res_s4.car_x   <= car_x;
			res_s4.car_y   <= car_y;
			res_s4.clipped <= clip_s3 || ovf_x || ovf_y;
		end
	end

	assign in_ready  = en_s1;
	assign out_valid = vld_s4;
	assign out_res   = res_s4;

	// an out-of-range quotient must come out flagged
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s4 && vld_s3 && (ovf_x || ovf_y)) |=> (vld_s4 && res_s4.clipped))
		else $error("saturated result without clipped flag");

endmodule

FILE: rtl/world_to_vehicle_frame_transform.sv
// Top level of the world-to-vehicle frame transform: pose registers, offset
// and half-turn stages, CORDIC and gain pipelines. Depends on w2vft_pkg.
//
// Takes one waypoint per clock while not stalled and returns it in the
// vehicle frame: two stages for the pose offset and the half-turn
// pre-rotation, one stage per CORDIC micro-rotation, and four for the gain
// multiply, rounding and saturation. Every stage holds its item under back
// pressure and empty stages fill up, so the input keeps taking transfers
// while a finished result waits. clipped is set when the offset or either
// output saturated. Write pose_x (0x0), pose_y (0x4) and heading (0x8) over
// the APB port only while no waypoint is in flight; pready is always high.
module world_to_vehicle_frame_transform #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wp_valid,
	output logic                                 wp_ready,
	input  w2vft_pkg::wp_t                       wp,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output w2vft_pkg::res_t                      res,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [w2vft_pkg::ADDR_WIDTH-1:0]     paddr,
	input  logic [w2vft_pkg::DATA_WIDTH-1:0]     pwdata,
	output logic [w2vft_pkg::DATA_WIDTH-1:0]     prdata,
	output logic                                 pready
);
	import w2vft_pkg::*;

	localparam logic signed [ANGLE_EXT-1:0] QTR  = ANGLE_EXT'(QUARTER_TURN);
	localparam logic signed [ANGLE_EXT-1:0] HALF = ANGLE_EXT'(HALF_TURN);

	logic signed [COORD_WIDTH-1:0]   pose_x_q, pose_y_q;
	logic [HEADING_WIDTH-1:0]        heading_q;
	logic                            wr_en;

	logic                            vld_s1, clip_s1;
	logic signed [COORD_WIDTH-1:0]   dx_s1, dy_s1;
	logic                            vld_s2;
	rot_t                            rot_s2;

	logic                            en_s1, en_s2;
	logic signed [DIFF_WIDTH-1:0]    dx_full, dy_full;
	logic                            ovf_dx, ovf_dy;
	logic [COORD_WIDTH-1:0]          dx_sat, dy_sat;
	logic [HEADING_WIDTH-1:0]        ang_neg;
	logic signed [ANGLE_EXT-1:0]     ang_s, ang_adj;
	logic                            flip;
	logic signed [ROT_WIDTH-1:0]     x_ext, y_ext;
	rot_t                            rot_nxt;

	logic                            cordic_ready, cordic_valid;
	rot_t                            cordic_rot;
	logic                            gain_ready;

	// configuration port
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q  <= '0;
			pose_y_q  <= '0;
			heading_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[ADDR_WIDTH-1:2]))
				REG_POSE_X:  pose_x_q  <= pwdata[COORD_WIDTH-1:0];
				REG_POSE_Y:  pose_y_q  <= pwdata[COORD_WIDTH-1:0];
				REG_HEADING: heading_q <= pwdata[HEADING_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[ADDR_WIDTH-1:2]))
			REG_POSE_X:  prdata = DATA_WIDTH'(pose_x_q);
			REG_POSE_Y:  prdata = DATA_WIDTH'(pose_y_q);
			REG_HEADING: prdata = DATA_WIDTH'(heading_q);
			default:     prdata = '0;
		endcase
	end

	// stage 1: pose offset with saturation
	always_comb begin
		dx_full = DIFF_WIDTH'(wp.world_x) - DIFF_WIDTH'(pose_x_q);
		dy_full = DIFF_WIDTH'(wp.world_y) - DIFF_WIDTH'(pose_y_q);
		ovf_dx  = dx_full[DIFF_WIDTH-1] != dx_full[DIFF_WIDTH-2];
		ovf_dy  = dy_full[DIFF_WIDTH-1] != dy_full[DIFF_WIDTH-2];
		dx_sat  = ovf_dx ? (dx_full[DIFF_WIDTH-1] ? COORD_MIN : COORD_MAX)
		                 : dx_full[COORD_WIDTH-1:0];
		dy_sat  = ovf_dy ? (dy_full[DIFF_WIDTH-1] ? COORD_MIN : COORD_MAX)
		                 : dy_full[COORD_WIDTH-1:0];
	end

	// stage 2: target angle is minus heading; fold beyond a quarter turn
	always_comb begin
		ang_neg = -heading_q;
		ang_s   = ANGLE_EXT'($signed(ang_neg));
		flip    = (ang_s > QTR) || (ang_s < -QTR);
		if (ang_s > QTR) begin
			ang_adj = ang_s - HALF;
		end else if (ang_s < -QTR) begin
			ang_adj = ang_s + HALF;
		end else begin
			ang_adj = ang_s;
		end
		x_ext        = ROT_WIDTH'(dx_s1) <<< GUARD_BITS;
		y_ext        = ROT_WIDTH'(dy_s1) <<< GUARD_BITS;
		rot_nxt.x    = flip ? -x_ext : x_ext;
		rot_nxt.y    = flip ? -y_ext : y_ext;
		rot_nxt.z    = {ang_adj, {(ANG_WIDTH-ANGLE_EXT){1'b0}}};
		rot_nxt.clip = clip_s1;
	end

	assign en_s2    = !vld_s2 || cordic_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign wp_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= wp_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && wp_valid) begin
			dx_s1   <= dx_sat;
			dy_s1   <= dy_sat;
			clip_s1 <= ovf_dx || ovf_dy;
		end
		if (en_s2 && vld_s1) begin
			rot_s2 <= rot_nxt;
		end
	end

	w2vft_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (cordic_ready),
		.in_rot    (rot_s2),
		.out_valid (cordic_valid),
		.out_ready (gain_ready),
		.out_rot   (cordic_rot)
	);

	w2vft_gain #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cordic_valid),
		.in_ready  (gain_ready),
		.in_rot    (cordic_rot),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_res   (res)
	);

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_valid && wp_ready) |=> vld_s1)
		else $error("accepted waypoint did not reach stage 1");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !cordic_ready) |=> (vld_s2 && $stable(rot_s2)))
		else $error("stage 2 lost or changed a stalled item");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for world_to_vehicle_frame_transform: drives waypoints
// and APB pose writes, predicts every vehicle-frame point and checks each one.
// Depends on w2vft_pkg and the top-level RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import w2vft_pkg::*;

	localparam int STEPS = 16;
	localparam int ROTATIONS = STEPS < 1 ? 1 : (STEPS > MAX_STEPS ? MAX_STEPS : STEPS);
	localparam int GAIN_SEL = STEPS < 8 ? 0 : (STEPS > 30 ? 22 : STEPS - 8);
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic [ADDR_WIDTH-1:0] ADDR_POSE_X  = {REG_POSE_X, 2'b00};
	localparam logic [ADDR_WIDTH-1:0] ADDR_POSE_Y  = {REG_POSE_Y, 2'b00};
	localparam logic [ADDR_WIDTH-1:0] ADDR_HEADING = {REG_HEADING, 2'b00};
	localparam logic [ADDR_WIDTH-1:0] ADDR_UNMAPPED = 4'hC;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wp_valid = 1'b0;
	logic wp_ready;
	wp_t wp = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr = '0;
	logic [DATA_WIDTH-1:0] pwdata = '0;
	logic [DATA_WIDTH-1:0] prdata;
	logic pready;

	// shadow copy of the pose registers
	logic signed [COORD_WIDTH-1:0] pose_x_q = '0;
	logic signed [COORD_WIDTH-1:0] pose_y_q = '0;
	logic [HEADING_WIDTH-1:0] heading_q = '0;

	// atan(2^-i) at 2^32 units per turn, and 2^30 / K_n for n = 8..30
	longint atan_turn [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10680862, 5345367, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};
	longint gain_recip [23] = '{
		652039507, 652034532, 652033289, 652032978, 652032900,
		652032881, 652032876, 652032874, 652032874, 652032874,
		652032874, 652032874, 652032874, 652032874, 652032874,
		652032874, 652032874, 652032874, 652032874, 652032874,
		652032874, 652032874, 652032874
	};

	res_t frames_due [$];
	int mismatches = 0;
	int n_waypoints = 0;
	int n_frames = 0;
	int n_reg_writes = 0;
	int gap_pct = 20;
	int stall_pct = 20;
	int stall_left = 0;
	int idle_cycles = 0;
	bit full_rate = 1'b0;

	world_to_vehicle_frame_transform #(
		.CORDIC_STEPS(STEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wp_valid(wp_valid),
		.wp_ready(wp_ready),
		.wp(wp),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic longint saturate(input longint v, inout bit clip);
		if (v > longint'(COORD_MAX)) begin
			clip = 1'b1;
			return longint'(COORD_MAX);
		end
		if (v < longint'(COORD_MIN)) begin
			clip = 1'b1;
			return longint'(COORD_MIN);
		end
		return v;
	endfunction

	// multiply by the inverse gain, drop 38 fraction bits, round half away from zero
	function automatic longint apply_gain(input longint v);
		logic [127:0] prod;
		longint mag;
		mag = (v < 0) ? -v : v;
		prod = (128'(mag) * 128'(gain_recip[GAIN_SEL]) + (128'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
		return (v < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic res_t to_vehicle_frame(input wp_t w);
		longint x, y, z, xs, ys, ang;
		bit clip;
		res_t r;
		clip = 1'b0;
		x = saturate(longint'(w.world_x) - longint'(pose_x_q), clip);
		y = saturate(longint'(w.world_y) - longint'(pose_y_q), clip);
		ang = (65536 - longint'(heading_q)) % 65536;
		if (ang >= HALF_TURN)
			ang -= 65536;
		x = x * (64'sd1 << GUARD_BITS);
		y = y * (64'sd1 << GUARD_BITS);
		// beyond a quarter turn: negate the vector and move the angle by a half turn
		if (ang > QUARTER_TURN) begin
			x = -x;
			y = -y;
			ang -= HALF_TURN;
		end else if (ang < -QUARTER_TURN) begin
			x = -x;
			y = -y;
			ang += HALF_TURN;
		end
		z = ang * 65536;
		for (int i = 0; i < ROTATIONS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= atan_turn[i];
			end else begin
				x += ys;
				y -= xs;
				z += atan_turn[i];
			end
		end
		x = saturate(apply_gain(x), clip);
		y = saturate(apply_gain(y), clip);
		r.car_x = x[COORD_WIDTH-1:0];
		r.car_y = y[COORD_WIDTH-1:0];
		r.clipped = clip;
		return r;
	endfunction

	// register writes seen on the bus
	always @(posedge clk) begin
		if (psel && penable && pwrite && pready) begin
			n_reg_writes++;
			case (paddr)
				ADDR_POSE_X: pose_x_q <= pwdata[COORD_WIDTH-1:0];
				ADDR_POSE_Y: pose_y_q <= pwdata[COORD_WIDTH-1:0];
				ADDR_HEADING: heading_q <= pwdata[HEADING_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (wp_valid && wp_ready) begin
			frames_due = {frames_due, to_vehicle_frame(wp)};
			n_waypoints++;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (res_valid && res_ready) begin
			n_frames++;
			if (frames_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected frame transfer car_x %h car_y %h clipped %b",
					$realtime, res.car_x, res.car_y, res.clipped);
			end else begin
				want = frames_due.pop_front();
				if (res.car_x !== want.car_x) begin
					mismatches++;
					$display("%0t: car_x expected %h actual %h", $realtime,
						want.car_x, res.car_x);
				end
				if (res.car_y !== want.car_y) begin
					mismatches++;
					$display("%0t: car_y expected %h actual %h", $realtime,
						want.car_y, res.car_y);
				end
				if (res.clipped !== want.clipped) begin
					mismatches++;
					$display("%0t: clipped expected %b actual %b", $realtime,
						want.clipped, res.clipped);
				end
			end
		end
	end

	// receiver back pressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (!full_rate && $urandom_range(99) < stall_pct) begin
			stall_left = $urandom_range(18, 1) - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((wp_valid && wp_ready) || (res_valid && res_ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_waypoint(input logic signed [COORD_WIDTH-1:0] wx,
		input logic signed [COORD_WIDTH-1:0] wy);
		int gap;
		if (!full_rate && $urandom_range(99) < gap_pct) begin
			gap = $urandom_range(18, 1);
			wp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		wp_valid <= 1'b1;
		wp <= wp_t'{world_x: wx, world_y: wy};
		do @(posedge clk); while (!wp_ready);
	endtask

	task automatic send_random_waypoint();
		logic signed [COORD_WIDTH-1:0] wx, wy;
		case ($urandom_range(9))
			0: begin
				wx = $urandom;
				wy = $urandom;
			end
			1: begin
				wx = $urandom_range(1) ? COORD_MAX : COORD_MIN;
				wy = $urandom_range(1) ? COORD_MAX : COORD_MIN;
			end
			default: begin
				// waypoints within about 128 m of the vehicle
				wx = pose_x_q + ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
				wy = pose_y_q + ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
			end
		endcase
		send_waypoint(wx, wy);
	endtask

	// every waypoint yields one frame, so an empty queue means an empty pipeline
	task automatic wait_drained();
		wp_valid <= 1'b0;
		do @(posedge clk); while (frames_due.size() != 0);
	endtask

	task automatic apb_write(input logic [ADDR_WIDTH-1:0] addr,
		input logic [DATA_WIDTH-1:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pose(input logic signed [COORD_WIDTH-1:0] px,
		input logic signed [COORD_WIDTH-1:0] py, input logic [HEADING_WIDTH-1:0] hd);
		wait_drained();
		apb_write(ADDR_POSE_X, px);
		apb_write(ADDR_POSE_Y, py);
		// upper data bits are don't-care for the heading register
		apb_write(ADDR_HEADING, {16'($urandom), hd});
	endtask

	task automatic test_directed_poses();
		logic [HEADING_WIDTH-1:0] sweep [6];
		sweep = '{16'd16385, 16'd32768, 16'd49151, 16'd49152, 16'd65535, 16'd1};
		set_pose('0, '0, 16'd0);
		send_waypoint('0, '0);
		send_waypoint(COORD_MAX, COORD_MIN);
		send_waypoint(COORD_MIN, COORD_MAX);
		send_waypoint(32'sd1, -32'sd1);
		// differences overflow in both directions
		set_pose(COORD_MIN, COORD_MAX, 16'd0);
		send_waypoint(COORD_MAX, COORD_MIN);
		send_waypoint('0, '0);
		// 45 degrees pushes the rotated corner points out of range
		set_pose('0, '0, 16'd8192);
		send_waypoint(COORD_MAX, COORD_MAX);
		send_waypoint(COORD_MIN, COORD_MIN);
		set_pose(32'sh0003_0000, -32'sh0001_8000, 16'd16384);
		send_waypoint(32'sh0005_0000, 32'sh0002_0000);
		foreach (sweep[i]) begin
			set_pose(32'sh0001_0000, 32'sh0002_0000, sweep[i]);
			send_waypoint(-32'sh0004_2000, 32'sh0007_8000);
		end
		// a write beyond the last register changes nothing
		wait_drained();
		apb_write(ADDR_UNMAPPED, 32'hDEAD_BEEF);
		apb_write(ADDR_HEADING, 32'hABCD_1001);
		send_waypoint(32'sh0010_0000, -32'sh0003_0000);
	endtask

	task automatic test_random_poses();
		logic signed [COORD_WIDTH-1:0] px, py;
		logic [HEADING_WIDTH-1:0] hd;
		int n;
		for (int p = 0; p < 14; p++) begin
			case ($urandom_range(4))
				0: px = COORD_MAX;
				1: px = COORD_MIN;
				2: px = '0;
				default: px = $urandom;
			endcase
			case ($urandom_range(4))
				0: py = COORD_MAX;
				1: py = COORD_MIN;
				2: py = '0;
				default: py = $urandom;
			endcase
			case ($urandom_range(6))
				0: hd = 16'd0;
				1: hd = 16'd16384;
				2: hd = 16'd32768;
				3: hd = 16'd49152;
				4: hd = 16'd65535;
				default: hd = 16'($urandom);
			endcase
			set_pose(px, py, hd);
			gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(50, 5);
			stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(50, 5);
			n = $urandom_range(140, 100);
			repeat (n) send_random_waypoint();
		end
	endtask

	task automatic test_full_rate();
		set_pose($urandom, $urandom, 16'($urandom));
		full_rate = 1'b1;
		repeat (150) send_random_waypoint();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_poses();
		test_random_poses();
		test_full_rate();
		wait_drained();
		repeat (ROTATIONS + 16) @(posedge clk);
		if (frames_due.size() != 0) begin
			mismatches++;
			$display("%0t: %0d frames never arrived", $realtime, frames_due.size());
		end
		$display("checked %0d frames from %0d waypoints over %0d register writes",
			n_frames, n_waypoints, n_reg_writes);
		$display("directed extremes, 14 random poses with stalls, one full-rate stream");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: world_to_vehicle_frame_transform.f
rtl/w2vft_pkg.sv
rtl/w2vft_cordic.sv
rtl/w2vft_gain.sv
rtl/world_to_vehicle_frame_transform.sv
bench/tb_top.sv
